>>> hdl/bcpe_pkg.sv
// Shared types and constants of the bit-chunk pulse pattern encoder.
// Holds job format, queue status, request and register codes.
// No dependencies.
`default_nettype none

package bcpe_pkg;

  // sizes of the tables and sequences
  localparam int SYMBOL_DEPTH_DEF = 128;
  localparam int MAX_SEQ_SYMBOLS  = 6;
  localparam int MAX_CHUNK_VALUES = 16;
  localparam int OFFSET_ENTRIES   = 20;

  // offset entry roles
  localparam int IDX_START   = 0;
  localparam int IDX_BETWEEN = 1;
  localparam int IDX_END     = 2;
  localparam int IDX_CHUNK0  = 3;

  // field and internal widths
  localparam int TADDR_W    = 7;
  localparam int WORD_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int VBITS_W    = 4;
  localparam int OFF_W      = 8;
  localparam int IDX_W      = 5;
  localparam int LEN_W      = 3;
  localparam int SEQ_ADDR_W = 9;
  localparam int ADDR_EXT_W = 10;
  localparam int CMP_W      = 11;
  localparam int S_TDATA_W  = 56;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST  = 2'd1;

  // input request kinds
  typedef enum logic [1:0] {
    REQ_SYM_WR = 2'd0,
    REQ_OFF_WR = 2'd1,
    REQ_DATA   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // job kinds handed to the back end
  typedef enum logic [1:0] {
    JOB_SEQ    = 2'd0,
    JOB_SYM_WR = 2'd1,
    JOB_OFF_WR = 2'd2,
    JOB_MARK   = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t            kind;
    logic [IDX_W-1:0]     idx;
    logic [TADDR_W-1:0]   addr;
    logic [WORD_W-1:0]    word;
    logic                 last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

>>> hdl/bcpe_queue.sv
// Short job queue between the front and back ends of the encoder.
// Depends on bcpe_pkg for the job type and queue sizes.
`default_nettype none

module bcpe_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bcpe_pkg::job_t  push_job,
  input  wire logic            pop,
  output bcpe_pkg::job_t       head,
  output bcpe_pkg::q_stat_t    stat
);

  bcpe_pkg::job_t                 entries [bcpe_pkg::QUEUE_DEPTH];
  logic [bcpe_pkg::QPTR_W-1:0]    wr_ptr;
  logic [bcpe_pkg::QPTR_W-1:0]    rd_ptr;
  logic [bcpe_pkg::QCNT_W-1:0]    count;

  // status and head entry
  assign stat = '{full:  (count == bcpe_pkg::QCNT_W'(bcpe_pkg::QUEUE_DEPTH)),
                  empty: (count == '0)};
  assign head = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bcpe_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bcpe_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + bcpe_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - bcpe_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/bcpe_front.sv
// Front end: accepts input words and config writes, splits each data byte
// into sequence jobs. Depends on bcpe_pkg; feeds bcpe_queue.
`default_nettype none

module bcpe_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [bcpe_pkg::S_TDATA_W-1:0]    s_tdata,
  input  wire logic [1:0]                        s_tuser,
  input  wire logic                              s_tlast,
  input  wire logic                              cfg_valid,
  input  wire logic [bcpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bcpe_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire bcpe_pkg::q_stat_t                 q_stat,
  output logic                                   push,
  output bcpe_pkg::job_t                         push_job
);

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_HEAD  = 5'b00010,
    F_CHUNK = 5'b00100,
    F_END   = 5'b01000,
    F_MARK  = 5'b10000
  } fstate_t;

  typedef enum logic [1:0] {
    CS_1 = 2'd0,
    CS_2 = 2'd1,
    CS_4 = 2'd2
  } chunk_sel_t;

  localparam logic [bcpe_pkg::IDX_W-1:0] MAX_CV =
    bcpe_pkg::IDX_W'(bcpe_pkg::MAX_CHUNK_VALUES);
  localparam logic [bcpe_pkg::VBITS_W-1:0] VBITS_MAX = 4'd8;

  fstate_t                          state;
  fstate_t                          state_next;
  logic                             frame_started;
  logic [2:0]                       chunk_bits;
  logic                             msb_first;
  logic [bcpe_pkg::BYTE_W-1:0]      work;
  logic [bcpe_pkg::VBITS_W-1:0]     left;
  logic [bcpe_pkg::IDX_W-1:0]       head_idx;
  logic                             last;

  logic                             accept;
  bcpe_pkg::req_t                   req;
  logic [bcpe_pkg::TADDR_W-1:0]     in_addr;
  logic [bcpe_pkg::WORD_W-1:0]      in_word;
  logic [bcpe_pkg::BYTE_W-1:0]      in_byte;
  logic [bcpe_pkg::VBITS_W-1:0]     in_vbits;
  logic [bcpe_pkg::VBITS_W-1:0]     vbits_clamped;
  logic [bcpe_pkg::VBITS_W-1:0]     nchunks;
  chunk_sel_t                       csel;
  logic [3:0]                       chunk_val;
  logic [bcpe_pkg::BYTE_W-1:0]      work_shifted;
  logic                             chunk_used;
  fstate_t                          after_chunks;

  // unpack the input word, lowest field first
  assign req      = bcpe_pkg::req_t'(s_tuser);
  assign in_addr  = s_tdata[6:0];
  assign in_word  = s_tdata[38:7];
  assign in_byte  = s_tdata[46:39];
  assign in_vbits = s_tdata[50:47];

  assign s_tready = (state == F_IDLE) && !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  // effective chunk size
  always_comb begin
    case (chunk_bits) inside
      [3'd0:3'd1]: csel = CS_1;
      [3'd2:3'd3]: csel = CS_2;
      default:     csel = CS_4;
    endcase
  end

  // chunk count from the clamped valid bits
  always_comb begin
    vbits_clamped = (in_vbits > VBITS_MAX) ? VBITS_MAX : in_vbits;
    case (csel)
      CS_1:    nchunks = vbits_clamped;
      CS_2:    nchunks = vbits_clamped >> 1;
      default: nchunks = vbits_clamped >> 2;
    endcase
  end

  // current chunk value and the byte shifted past it
  always_comb begin
    case (csel)
      CS_1: begin
        chunk_val    = msb_first ? {3'b000, work[7]} : {3'b000, work[0]};
        work_shifted = msb_first ? (work << 1) : (work >> 1);
      end
      CS_2: begin
        chunk_val    = msb_first ? {2'b00, work[7:6]} : {2'b00, work[1:0]};
        work_shifted = msb_first ? (work << 2) : (work >> 2);
      end
      default: begin
        chunk_val    = msb_first ? work[7:4] : work[3:0];
        work_shifted = msb_first ? (work << 4) : (work >> 4);
      end
    endcase
    chunk_used = ({1'b0, chunk_val} < MAX_CV);
  end

  assign after_chunks = last ? F_END : F_MARK;

  // job generation and state sequencing
  always_comb begin
    state_next    = state;
    push          = 1'b0;
    push_job      = '0;
    push_job.kind = bcpe_pkg::JOB_SEQ;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          push_job.addr = in_addr;
          push_job.word = in_word;
          unique case (req)
            bcpe_pkg::REQ_SYM_WR: begin
              push          = 1'b1;
              push_job.kind = bcpe_pkg::JOB_SYM_WR;
            end
            bcpe_pkg::REQ_OFF_WR: begin
              push          = 1'b1;
              push_job.kind = bcpe_pkg::JOB_OFF_WR;
            end
            bcpe_pkg::REQ_DATA: state_next = F_HEAD;
            default: ;
          endcase
        end
      end
      F_HEAD: begin
        if (!q_stat.full) begin
          push         = 1'b1;
          push_job.idx = head_idx;
          state_next   = (left != '0) ? F_CHUNK : after_chunks;
        end
      end
      F_CHUNK: begin
        if (!q_stat.full) begin
          push         = chunk_used;
          push_job.idx = bcpe_pkg::IDX_W'(bcpe_pkg::IDX_CHUNK0) + {1'b0, chunk_val};
          if (left == bcpe_pkg::VBITS_W'(1)) begin
            state_next = after_chunks;
          end
        end
      end
      F_END: begin
        if (!q_stat.full) begin
          push         = 1'b1;
          push_job.idx = bcpe_pkg::IDX_W'(bcpe_pkg::IDX_END);
          state_next   = F_MARK;
        end
      end
      F_MARK: begin
        if (!q_stat.full) begin
          push          = 1'b1;
          push_job.kind = bcpe_pkg::JOB_MARK;
          push_job.last = last;
          state_next    = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      frame_started <= 1'b0;
      chunk_bits    <= 3'd1;
      msb_first     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && req == bcpe_pkg::REQ_DATA) begin
        frame_started <= !s_tlast;
      end
      if (cfg_valid) begin
        case (cfg_index)
          bcpe_pkg::CFG_CHUNK_BITS: chunk_bits <= cfg_data[2:0];
          bcpe_pkg::CFG_MSB_FIRST:  msb_first  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // per-byte working registers
  always_ff @(posedge clk) begin
    if (accept && req == bcpe_pkg::REQ_DATA) begin
      work     <= in_byte;
      left     <= nchunks;
      last     <= s_tlast;
      head_idx <= frame_started ? bcpe_pkg::IDX_W'(bcpe_pkg::IDX_BETWEEN)
                                : bcpe_pkg::IDX_W'(bcpe_pkg::IDX_START);
    end else if (state == F_CHUNK && !q_stat.full) begin
      work <= work_shifted;
      left <= left - bcpe_pkg::VBITS_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> hdl/bcpe_back.sv
// Back end: runs table writes and sequence jobs against the offset and symbol
// memories, and streams symbol words out. Depends on bcpe_pkg; fed by bcpe_queue.
`default_nettype none

module bcpe_back #(
  parameter int SYMBOL_DEPTH = bcpe_pkg::SYMBOL_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire bcpe_pkg::q_stat_t              q_stat,
  input  wire bcpe_pkg::job_t                 head,
  output logic                                pop,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [bcpe_pkg::WORD_W-1:0]         m_tdata,
  output logic                                m_tlast,
  output logic                                m_tuser
);

  localparam int AW = $clog2(SYMBOL_DEPTH);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_LEN   = 4'b0010,
    B_RUN   = 4'b0100,
    B_FLUSH = 4'b1000
  } bstate_t;

  bstate_t                              state;
  bstate_t                              state_next;

  logic [bcpe_pkg::WORD_W-1:0]          sym_mem [SYMBOL_DEPTH];
  logic [bcpe_pkg::OFF_W-1:0]           off_mem [bcpe_pkg::OFFSET_ENTRIES];

  logic [bcpe_pkg::OFF_W-1:0]           off_start;
  logic [bcpe_pkg::OFF_W-1:0]           off_next;
  logic [bcpe_pkg::SEQ_ADDR_W-1:0]      seq_addr;
  logic [bcpe_pkg::LEN_W-1:0]           seq_left;
  logic                                 mark_last;
  logic                                 d_valid;
  logic [bcpe_pkg::WORD_W-1:0]          rdata;
  logic                                 h_valid;
  logic [bcpe_pkg::WORD_W-1:0]          h_word;
  logic                                 out_valid;
  logic [bcpe_pkg::WORD_W-1:0]          out_word;
  logic                                 out_last;
  logic                                 out_done;

  logic                                 out_ok;
  logic                                 d_move;
  logic                                 issue;
  logic                                 flush;
  logic                                 wr_sym;
  logic                                 wr_off;
  logic                                 rd_off;
  logic                                 rd_in_range;
  logic [bcpe_pkg::ADDR_EXT_W-1:0]      wr_ext;
  logic [bcpe_pkg::ADDR_EXT_W-1:0]      rd_ext;
  logic [bcpe_pkg::OFF_W-1:0]           diff;
  logic [bcpe_pkg::LEN_W-1:0]           len_now;
  logic [bcpe_pkg::IDX_W-1:0]           idx_plus;

  // handshake between the read stage, the hold word and the output register
  assign out_ok = !out_valid || m_tready;
  assign d_move = d_valid && (!h_valid || out_ok);
  assign issue  = (state == B_RUN) && (!d_valid || d_move);
  assign flush  = (state == B_FLUSH) && !d_valid && h_valid && out_ok;
  assign pop    = (state == B_IDLE) && !q_stat.empty;

  // job decode
  assign wr_sym = pop && head.kind == bcpe_pkg::JOB_SYM_WR &&
                  (bcpe_pkg::CMP_W'(head.addr) < bcpe_pkg::CMP_W'(SYMBOL_DEPTH));
  assign wr_off = pop && head.kind == bcpe_pkg::JOB_OFF_WR &&
                  (bcpe_pkg::CMP_W'(head.addr) < bcpe_pkg::CMP_W'(bcpe_pkg::OFFSET_ENTRIES));
  assign rd_off = pop && head.kind == bcpe_pkg::JOB_SEQ;

  assign rd_in_range = bcpe_pkg::CMP_W'(seq_addr) < bcpe_pkg::CMP_W'(SYMBOL_DEPTH);
  assign wr_ext      = bcpe_pkg::ADDR_EXT_W'(head.addr);
  assign rd_ext      = bcpe_pkg::ADDR_EXT_W'(seq_addr);
  assign idx_plus    = head.idx + bcpe_pkg::IDX_W'(1);

  // sequence length, clipped to the longest allowed run
  always_comb begin
    diff = off_next - off_start;
    if (off_next <= off_start) begin
      len_now = '0;
    end else if (diff > bcpe_pkg::OFF_W'(bcpe_pkg::MAX_SEQ_SYMBOLS)) begin
      len_now = bcpe_pkg::LEN_W'(bcpe_pkg::MAX_SEQ_SYMBOLS);
    end else begin
      len_now = diff[bcpe_pkg::LEN_W-1:0];
    end
  end

  // state sequencing
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (pop) begin
          case (head.kind)
            bcpe_pkg::JOB_SEQ:  state_next = B_LEN;
            bcpe_pkg::JOB_MARK: state_next = B_FLUSH;
            default: ;
          endcase
        end
      end
      B_LEN:   state_next = (len_now == '0) ? B_IDLE : B_RUN;
      B_RUN: begin
        if (issue && seq_left == bcpe_pkg::LEN_W'(1)) begin
          state_next = B_IDLE;
        end
      end
      B_FLUSH: begin
        if (!d_valid && (!h_valid || out_ok)) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // symbol memory, registered read
  always_ff @(posedge clk) begin
    if (wr_sym) begin
      sym_mem[wr_ext[AW-1:0]] <= head.word;
    end
    if (issue) begin
      rdata <= rd_in_range ? sym_mem[rd_ext[AW-1:0]] : '0;
    end
  end

  // offset memory, two registered reads
  always_ff @(posedge clk) begin
    if (wr_off) begin
      off_mem[head.addr[bcpe_pkg::IDX_W-1:0]] <= head.word[bcpe_pkg::OFF_W-1:0];
    end
    if (rd_off) begin
      off_start <= off_mem[head.idx];
      off_next  <= off_mem[idx_plus];
    end
  end

  // sequence walker and payload registers
  always_ff @(posedge clk) begin
    if (state == B_LEN) begin
      seq_addr <= bcpe_pkg::SEQ_ADDR_W'(off_start);
      seq_left <= len_now;
    end else if (issue) begin
      seq_addr <= seq_addr + bcpe_pkg::SEQ_ADDR_W'(1);
      seq_left <= seq_left - bcpe_pkg::LEN_W'(1);
    end
    if (pop && head.kind == bcpe_pkg::JOB_MARK) begin
      mark_last <= head.last;
    end
    if (d_move) begin
      h_word <= rdata;
    end
    if (d_move && h_valid) begin
      out_word <= h_word;
      out_last <= 1'b0;
      out_done <= 1'b0;
    end else if (flush) begin
      out_word <= h_word;
      out_last <= 1'b1;
      out_done <= mark_last;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      d_valid   <= 1'b0;
      h_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (issue) begin
        d_valid <= 1'b1;
      end else if (d_move) begin
        d_valid <= 1'b0;
      end
      if (d_move) begin
        h_valid <= 1'b1;
      end else if (flush) begin
        h_valid <= 1'b0;
      end
      if ((d_move && h_valid) || flush) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_word;
  assign m_tlast  = out_last;
  assign m_tuser  = out_done;

endmodule

`default_nettype wire

>>> hdl/bit_chunk_pulse_pattern_encoder_unit.sv
// Bit-chunk pulse pattern encoder, top level.
// Channels: s_* takes table writes and data bytes (s_tuser is the request
// kind: symbol write, offset write, data byte), s_tlast marks the frame's
// last byte. m_* gives 32-bit symbol words; m_tlast marks the last word
// caused by one input word, m_tuser flags the word that closes a frame.
// cfg_* writes chunk_bits (index 0) and msb_first (index 1), always ready.
// The front takes a table write and stays ready while the queue has room; a
// data byte is split into jobs, pushed one per cycle while the queue is not
// full (head sequence, each chunk, an end sequence on a frame's last byte only,
// closing mark), and s_tready is low until the closing mark is pushed. The
// back pops one job per idle cycle; a sequence job passes offset lookup and
// length, then reads one symbol per cycle from the symbol memory while the
// output is not stalled, and a closing mark flushes the hold word.
// Symbols go from the symbol read through the hold word to the output; the last
// symbol of a byte waits in a hold word until its closing mark is seen.
// Reset clears the control state, the queue and frame tracking; the symbol
// and offset tables are not cleared and must be loaded before use.
// When m_tready is low the back end holds at most one word in flight plus
// the hold and output words, and the job queue fills until the front stops.
// Depends on bcpe_pkg, bcpe_front, bcpe_queue and bcpe_back.
`default_nettype none

module bit_chunk_pulse_pattern_encoder_unit #(
  parameter int SYMBOL_DEPTH = bcpe_pkg::SYMBOL_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // table_addr[6:0], table_word[38:7], data_byte[46:39], valid_bits[50:47], zero pad
  input  wire logic [bcpe_pkg::S_TDATA_W-1:0]   s_tdata,
  // req_type[1:0]
  input  wire logic [1:0]                       s_tuser,
  input  wire logic                             s_tlast,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // symbol_word[31:0]
  output logic [bcpe_pkg::WORD_W-1:0]           m_tdata,
  // frame_done[0]
  output logic                                  m_tuser,
  output logic                                  m_tlast,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bcpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bcpe_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic               push;
  bcpe_pkg::job_t     push_job;
  logic               pop;
  bcpe_pkg::job_t     head;
  bcpe_pkg::q_stat_t  q_stat;

  assign cfg_ready = 1'b1;

  // front: accept and split items into jobs
  bcpe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // job queue
  bcpe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // back: table access and symbol output
  bcpe_back #(
    .SYMBOL_DEPTH (SYMBOL_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
